[rtl/hqs_pkg.sv]
// Shared widths and sequencer state codes for the quicksort engine.
package hqs_pkg;

	localparam int VALUE_W = 32;
	localparam int STATE_W = 4;

	localparam logic [STATE_W-1:0] ST_LOAD   = 4'd0;
	localparam logic [STATE_W-1:0] ST_SINIT  = 4'd1;
	localparam logic [STATE_W-1:0] ST_POP    = 4'd2;
	localparam logic [STATE_W-1:0] ST_POPW   = 4'd3;
	localparam logic [STATE_W-1:0] ST_PIV    = 4'd4;
	localparam logic [STATE_W-1:0] ST_SCANI  = 4'd5;
	localparam logic [STATE_W-1:0] ST_SCANJ  = 4'd6;
	localparam logic [STATE_W-1:0] ST_SWAP   = 4'd7;
	localparam logic [STATE_W-1:0] ST_RDI    = 4'd8;
	localparam logic [STATE_W-1:0] ST_PUSHA  = 4'd9;
	localparam logic [STATE_W-1:0] ST_PUSHB  = 4'd10;
	localparam logic [STATE_W-1:0] ST_EMRD   = 4'd11;
	localparam logic [STATE_W-1:0] ST_EMW    = 4'd12;
	localparam logic [STATE_W-1:0] ST_EMHOLD = 4'd13;

	typedef logic [VALUE_W-1:0] value_t;

endpackage

[rtl/hoare_quicksort_engine.sv]
// Batch sorter: loads words, sorts them by Hoare quicksort, streams them out.
//
// Channel   Direction  Words per batch         Payload
// s_axis    in         1 .. any (excess drop)  tdata = value, tlast = last
// m_axis    out        stored count            tdata = sorted_value,
//                                              tlast = final_res, tuser = dropped
//
// Loading accepts one word per cycle, and s_axis_tready is high only while loading, up to a batch's last word.
// Sorting compares against a store with a registered read port.
// Emitting holds each word until the output takes it, and only then reads the next.
// No clearing pass is needed after reset.
module hoare_quicksort_engine #(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] dropped
);

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	logic [hqs_pkg::STATE_W-1:0] state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     sp_q;
	logic              ovf_q;
	logic [IW-1:0]     lo_q, hi_q, i_q, j_q, k_q;
	hqs_pkg::value_t   pivot_q, vi_q;
	logic              out_valid_q, out_last_q, out_drop_q;
	hqs_pkg::value_t   out_data_q;

	logic              st_we;
	logic [IW-1:0]     st_waddr, st_raddr;
	hqs_pkg::value_t   st_wdata, st_rdata;
	logic              sk_we;
	logic [IW-1:0]     sk_waddr, sk_raddr;
	logic [2*IW-1:0]   sk_wdata, sk_rdata;

	logic              in_acc;
	logic              less_piv, more_piv;
	logic [CW-1:0]     mid_sum;
	logic [IW-1:0]     pop_lo, pop_hi;
	logic [CW-1:0]     j_inc;
	logic              is_final;
	logic [CW-1:0]     count_m1;

	function automatic logic [IW-1:0] count_sp_m1(input logic [CW-1:0] sp);
		logic [CW-1:0] d;
		d = sp - CW'(1);
		return d[IW-1:0];
	endfunction

	hqs_ram #(.WIDTH(hqs_pkg::VALUE_W), .DEPTH(MAX_ITEMS), .AW(IW)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	hqs_ram #(.WIDTH(2*IW), .DEPTH(MAX_ITEMS), .AW(IW)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
		.raddr(sk_raddr), .rdata(sk_rdata)
	);

	assign s_axis_tready = (state_q == hqs_pkg::ST_LOAD);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign less_piv = $signed(st_rdata) < $signed(pivot_q);
	assign more_piv = $signed(st_rdata) > $signed(pivot_q);
	assign pop_lo = sk_rdata[2*IW-1:IW];
	assign pop_hi = sk_rdata[IW-1:0];
	assign mid_sum = {1'b0, pop_lo} + {1'b0, pop_hi};
	assign j_inc = {1'b0, j_q} + CW'(1);
	assign count_m1 = count_q - CW'(1);
	assign is_final = ({1'b0, k_q} == count_m1);

	always_comb begin
		st_we = 1'b0;
		st_waddr = '0;
		st_wdata = s_axis_tdata;
		st_raddr = '0;
		sk_we = 1'b0;
		sk_waddr = '0;
		sk_wdata = '0;
		sk_raddr = '0;
		case (state_q)
			hqs_pkg::ST_LOAD: begin
				st_we = in_acc && (count_q < MAX_CNT);
				st_waddr = count_q[IW-1:0];
			end
			hqs_pkg::ST_SINIT: begin
				sk_we = 1'b1;
				sk_wdata = {IW'(0), count_m1[IW-1:0]};
			end
			hqs_pkg::ST_POP: begin
				sk_raddr = count_sp_m1(sp_q);
			end
			hqs_pkg::ST_POPW: begin
				st_raddr = mid_sum[IW:1];
			end
			hqs_pkg::ST_PIV: begin
				st_raddr = i_q;
			end
			hqs_pkg::ST_RDI: begin
				st_raddr = i_q;
			end
			hqs_pkg::ST_SCANI: begin
				st_raddr = less_piv ? (i_q + IW'(1)) : j_q;
			end
			hqs_pkg::ST_SCANJ: begin
				st_raddr = j_q - IW'(1);
				if (!more_piv && (i_q < j_q)) begin
					st_we = 1'b1;
					st_waddr = i_q;
					st_wdata = st_rdata;
				end
			end
			hqs_pkg::ST_SWAP: begin
				st_we = 1'b1;
				st_waddr = j_q;
				st_wdata = vi_q;
			end
			hqs_pkg::ST_PUSHA: begin
				sk_we = (j_inc < {1'b0, hi_q}) && (sp_q < MAX_CNT);
				sk_waddr = sp_q[IW-1:0];
				sk_wdata = {j_inc[IW-1:0], hi_q};
			end
			hqs_pkg::ST_PUSHB: begin
				sk_we = (lo_q < j_q) && (sp_q < MAX_CNT);
				sk_waddr = sp_q[IW-1:0];
				sk_wdata = {lo_q, j_q};
			end
			hqs_pkg::ST_EMRD: begin
				st_raddr = k_q;
			end
			default: begin
				st_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hqs_pkg::ST_LOAD;
			count_q <= '0;
			sp_q <= '0;
			ovf_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			pivot_q <= '0;
			vi_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			out_last_q <= 1'b0;
			out_drop_q <= 1'b0;
		end else begin
			case (state_q)
				hqs_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (count_q < MAX_CNT) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= hqs_pkg::ST_SINIT;
						end
					end
				end
				hqs_pkg::ST_SINIT: begin
					k_q <= '0;
					if (count_q < CW'(2)) begin
						sp_q <= '0;
						state_q <= hqs_pkg::ST_EMRD;
					end else begin
						sp_q <= CW'(1);
						state_q <= hqs_pkg::ST_POP;
					end
				end
				hqs_pkg::ST_POP: begin
					if (sp_q == '0) begin
						state_q <= hqs_pkg::ST_EMRD;
					end else begin
						sp_q <= sp_q - CW'(1);
						state_q <= hqs_pkg::ST_POPW;
					end
				end
				hqs_pkg::ST_POPW: begin
					lo_q <= pop_lo;
					hi_q <= pop_hi;
					i_q <= pop_lo;
					j_q <= pop_hi;
					state_q <= (pop_lo < pop_hi) ? hqs_pkg::ST_PIV : hqs_pkg::ST_POP;
				end
				hqs_pkg::ST_PIV: begin
					pivot_q <= st_rdata;
					state_q <= hqs_pkg::ST_SCANI;
				end
				hqs_pkg::ST_SCANI: begin
					if (less_piv) begin
						i_q <= i_q + IW'(1);
					end else begin
						vi_q <= st_rdata;
						state_q <= hqs_pkg::ST_SCANJ;
					end
				end
				hqs_pkg::ST_SCANJ: begin
					if (more_piv) begin
						j_q <= j_q - IW'(1);
					end else if (i_q < j_q) begin
						state_q <= hqs_pkg::ST_SWAP;
					end else begin
						state_q <= hqs_pkg::ST_PUSHA;
					end
				end
				hqs_pkg::ST_SWAP: begin
					i_q <= i_q + IW'(1);
					j_q <= j_q - IW'(1);
					state_q <= hqs_pkg::ST_RDI;
				end
				hqs_pkg::ST_RDI: begin
					state_q <= hqs_pkg::ST_SCANI;
				end
				hqs_pkg::ST_PUSHA: begin
					if (sk_we) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= hqs_pkg::ST_PUSHB;
				end
				hqs_pkg::ST_PUSHB: begin
					if (sk_we) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= hqs_pkg::ST_POP;
				end
				hqs_pkg::ST_EMRD: begin
					state_q <= hqs_pkg::ST_EMW;
				end
				hqs_pkg::ST_EMW: begin
					out_valid_q <= 1'b1;
					out_data_q <= st_rdata;
					out_last_q <= is_final;
					out_drop_q <= ovf_q;
					state_q <= hqs_pkg::ST_EMHOLD;
				end
				hqs_pkg::ST_EMHOLD: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q <= '0;
							sp_q <= '0;
							ovf_q <= 1'b0;
							state_q <= hqs_pkg::ST_LOAD;
						end else begin
							k_q <= k_q + IW'(1);
							state_q <= hqs_pkg::ST_EMRD;
						end
					end
				end
				default: begin
					state_q <= hqs_pkg::ST_LOAD;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tuser = out_drop_q;

endmodule

[rtl/hqs_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module hqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/hqs_checker.sv]
// Port-level checks for the quicksort engine and the bind that attaches them.
module hqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// Loading and emitting never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("output word offered while input is open");

	// The word that closes a batch starts the sort and closes the input.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("input still open after the last word of a batch");

	// After the final sorted word the output goes quiet and input reopens.
	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
		else $error("batch did not end after the final word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser)))
		else $error("stalled output word changed");

endmodule

bind hoare_quicksort_engine hqs_checker u_hqs_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the quicksort engine: batches go in, each word out is checked.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BATCH_CAP = 64;
	localparam int ITEM_GOAL = 370;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 600;
	localparam int MAX_REPORTS = 10;

	typedef logic signed [hqs_pkg::VALUE_W-1:0] svalue_t;

	typedef struct packed {
		hqs_pkg::value_t val;
		logic            fin;
		logic            drop;
	} sorted_word_t;

	typedef struct packed {
		hqs_pkg::value_t val;
		logic            last;
		logic            typed;
		hqs_pkg::value_t exp_val;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	// Single-word batches carry their result typed in; longer batches go through the sorter.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
		'{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0004, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0003, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b1, 1'b0, 32'h0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
		'{32'h5555_5555, 1'b1, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0}
	};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	hqs_pkg::value_t s_axis_tdata = '0;
	logic            s_axis_tlast = 1'b0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	hqs_pkg::value_t m_axis_tdata;
	logic            m_axis_tlast;
	logic            m_axis_tuser;

	svalue_t      batch_vals [BATCH_CAP];
	int           batch_len = 0;
	logic         batch_lost = 1'b0;
	sorted_word_t sorted_due [$];

	int fail_count = 0;
	int words_seen = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int hold_left = 0;
	logic held_once = 1'b0;
	int rx_mode = 0;
	int mode_left = 0;

	hoare_quicksort_engine #(.MAX_ITEMS(BATCH_CAP)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Pending ranges sit on a stack; each range is split around its middle element.
	function automatic void hoare_sort_batch();
		int lo_stack [$];
		int hi_stack [$];
		int lo;
		int hi;
		int i;
		int j;
		svalue_t piv;
		svalue_t t;
		if (batch_len < 2) return;
		lo_stack.push_back(0);
		hi_stack.push_back(batch_len - 1);
		while (lo_stack.size() > 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			piv = batch_vals[(lo + hi) / 2];
			i = lo - 1;
			j = hi + 1;
			forever begin
				i++;
				while (batch_vals[i] < piv) i++;
				j--;
				while (batch_vals[j] > piv) j--;
				if (i >= j) break;
				t = batch_vals[i];
				batch_vals[i] = batch_vals[j];
				batch_vals[j] = t;
			end
			if (j + 1 < hi) begin
				lo_stack.push_back(j + 1);
				hi_stack.push_back(hi);
			end
			if (lo < j) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(j);
			end
		end
	endfunction

	function automatic void absorb_word(hqs_pkg::value_t v, logic l, logic typed,
		hqs_pkg::value_t exp_val);
		if (batch_len < BATCH_CAP) begin
			batch_vals[batch_len] = svalue_t'(v);
			batch_len++;
		end else begin
			batch_lost = 1'b1;
		end
		if (!l) return;
		if (typed) begin
			sorted_due.push_back('{exp_val, 1'b1, 1'b0});
		end else begin
			hoare_sort_batch();
			for (int k = 0; k < batch_len; k++)
				sorted_due.push_back('{hqs_pkg::value_t'(batch_vals[k]), k == batch_len - 1,
					batch_lost});
		end
		batch_len = 0;
		batch_lost = 1'b0;
	endfunction

	function automatic hqs_pkg::value_t pick_value(int style);
		case (style)
			0: return hqs_pkg::value_t'($urandom_range(0, 8)) - 32'd4;
			1: begin
				case ($urandom_range(0, 5))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0000_0000;
					default: return $urandom();
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(hqs_pkg::value_t v, logic l, logic typed, hqs_pkg::value_t exp_val);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		absorb_word(v, l, typed, exp_val);
		items_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
	endtask

	task automatic send_batch(int n);
		int style;
		style = $urandom_range(0, 3);
		for (int k = 0; k < n; k++)
			send_word(pick_value(style), k == n - 1, 1'b0, '0);
	endtask

	task automatic report_mismatch(string what, sorted_word_t want, sorted_word_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s: expected value %h last %b dropped %b, got value %h last %b dropped %b",
				what, want.val, want.fin, want.drop, got.val, got.fin, got.drop);
	endtask

	always @(posedge clk) begin
		sorted_word_t want;
		sorted_word_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_seen <= words_seen + 1;
			got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
			if (sorted_due.size() == 0) begin
				report_mismatch("Unexpected word", '0, got);
			end else begin
				want = sorted_due.pop_front();
				if (got !== want) report_mismatch("Mismatch", want, got);
			end
		end
	end

	// The output side stalls on changing patterns, with one long hold-off while words pile up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!held_once && words_seen >= 100 && m_axis_tvalid) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (cycle_count % 4 == 0);
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < DIR_ROWS; r++)
			send_word(dir_rows[r].val, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].exp_val);
		// A batch that fills the store exactly, then one whose last word arrives when it is full.
		send_batch(BATCH_CAP);
		send_batch(BATCH_CAP + 6);
		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 19))
				0: n = BATCH_CAP;
				1: n = $urandom_range(BATCH_CAP + 1, BATCH_CAP + 8);
				2, 3, 4, 5: n = $urandom_range(11, 32);
				default: n = $urandom_range(1, 10);
			endcase
			send_batch(n);
		end
		s_axis_tvalid <= 1'b0;
		while (sorted_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
